@@ sv/upd_pkg.sv @@
package upd_pkg;

   // escape phase codes
   typedef logic [1:0] phase_type;
   localparam phase_type PHASE_PLAIN = 2'd0;
   localparam phase_type PHASE_HIGH  = 2'd1;
   localparam phase_type PHASE_LOW   = 2'd2;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [4:0] DIGIT_G    = 5'd16;

   typedef struct packed {
      phase_type  phase;
      logic [4:0] high_digit;
   } upd_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       truncated;
      logic       out_last;
   } upd_result_type;

   // hex digit value, g/G gives 16, anything else 0
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [7:0] lc;
      lc = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         lc = c + 8'h20;
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         return {1'b0, c[3:0]};
      end else if (lc >= 8'h61 && lc <= 8'h66) begin
         return 5'(lc - 8'h61 + 8'd10);
      end else if (lc == 8'h67) begin
         return DIGIT_G;
      end else begin
         return 5'd0;
      end
   endfunction

endpackage

@@ sv/upd_step.sv @@
module upd_step
   import upd_pkg::*;
(
   input  upd_state_type  cur_state,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output upd_state_type  next_state,
   output upd_result_type result
);

   logic [4:0] digit;
   logic [7:0] esc_value;
   upd_state_type  st;
   upd_result_type res;

   assign digit     = digit_value(in_byte);
   // high*16 + low kept to 8 bits
   assign esc_value = {cur_state.high_digit[3:0], 4'b0000} + {3'b000, digit};

   always_comb begin
      st  = cur_state;
      res = '0;
      res.out_last = in_last;
      case (cur_state.phase)
         PHASE_HIGH: begin
            st.high_digit = digit;
            st.phase      = PHASE_LOW;
         end
         PHASE_LOW: begin
            res.out_byte  = esc_value;
            res.out_valid = (esc_value != 8'd0);
            st.phase      = PHASE_PLAIN;
            st.high_digit = 5'd0;
         end
         default: begin
            st.phase = PHASE_PLAIN;
            if (in_byte == CH_PLUS) begin
               res.out_byte  = CH_SPACE;
               res.out_valid = 1'b1;
            end else if (in_byte == CH_PERCENT) begin
               st.phase      = PHASE_HIGH;
               st.high_digit = 5'd0;
            end else begin
               res.out_byte  = in_byte;
               res.out_valid = 1'b1;
            end
         end
      endcase
      // string end inside an open escape
      if (in_last) begin
         if (st.phase != PHASE_PLAIN) begin
            res.truncated = 1'b1;
            res.out_valid = 1'b0;
            res.out_byte  = 8'd0;
         end
         st.phase      = PHASE_PLAIN;
         st.high_digit = 5'd0;
      end
      next_state = st;
      result     = res;
   end

endmodule

@@ sv/url_percent_decoder_unit.sv @@
// an accepted req word is decoded combinationally and its rsp word is registered in the result register
// throughput: one word per cycle when rsp does not stall, set by the single escape-state register update
// req_ready stays high while the result register is empty or being drained
// reset: synchronous active high, clears the escape state and the result valid;
// payload registers are not reset
module url_percent_decoder_unit
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_truncated,
   output logic       rsp_out_last
);

   // escape state carried between words
   upd_state_type  state_ff;
   upd_state_type  state_in;
   // result register, parts the two channels
   upd_result_type result_ff;
   upd_result_type result_in;
   logic           rsp_valid_ff;
   logic           req_accept;

   // accept whenever the result slot is free or is being taken this cycle
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // per-word decode and phase update
   upd_step u_step (
      .cur_state  (state_ff),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .next_state (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = result_ff.out_byte;
   assign rsp_out_valid = result_ff.out_valid;
   assign rsp_truncated = result_ff.truncated;
   assign rsp_out_last  = result_ff.out_last;

   // a final word always closes any open escape
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_in_last) |=> (state_ff.phase == PHASE_PLAIN
                                       && state_ff.high_digit == 5'd0))
      else $error("escape state not cleared after final word");

   // unused phase code never reached
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != 2'd3)
      else $error("escape phase holds unused code");

   // truncation only on a final word, and never with a decoded byte
   a_trunc_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |-> (rsp_out_last && !rsp_out_valid))
      else $error("truncated result malformed");

   // no decoded byte means a zero byte field
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |-> (rsp_out_byte == 8'd0))
      else $error("byte field nonzero without a decoded byte");

endmodule

@@ tb/sv/upd_stream_checker.sv @@
module upd_stream_checker
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_valid,
   input  logic       rsp_truncated,
   input  logic       rsp_out_last,
   output int         fail_count,
   output int         words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type      esc_phase;
   logic [4:0]     esc_high;
   upd_result_type decoded_q[$];
   int             mismatches;

   initial begin
      fail_count    = 0;
      words_pending = 0;
      mismatches    = 0;
      esc_phase     = PHASE_PLAIN;
      esc_high      = 5'd0;
   end

   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] folded;
      folded = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
      if (c >= 8'h30 && c <= 8'h39) begin
         return 5'(c - 8'h30);
      end else if (folded >= 8'h61 && folded <= 8'h66) begin
         return 5'(folded - 8'h57);
      end else if (folded == 8'h67) begin
         return DIGIT_G;
      end
      return 5'd0;
   endfunction

   // decode one raw byte against the running escape state
   task automatic predict_decode(input logic [7:0] b, input logic l,
                                 output upd_result_type r);
      logic [8:0] esc_value;
      r          = '0;
      r.out_last = l;
      case (esc_phase)
         PHASE_HIGH: begin
            esc_high  = hex_nibble(b);
            esc_phase = PHASE_LOW;
         end
         PHASE_LOW: begin
            esc_value = {esc_high, 4'h0} + 9'(hex_nibble(b));
            if (esc_value[7:0] != 8'h00) begin
               r.out_byte  = esc_value[7:0];
               r.out_valid = 1'b1;
            end
            esc_phase = PHASE_PLAIN;
            esc_high  = 5'd0;
         end
         default: begin
            if (b == CH_PLUS) begin
               r.out_byte  = CH_SPACE;
               r.out_valid = 1'b1;
               esc_phase   = PHASE_PLAIN;
            end else if (b == CH_PERCENT) begin
               esc_phase = PHASE_HIGH;
               esc_high  = 5'd0;
            end else begin
               r.out_byte  = b;
               r.out_valid = 1'b1;
               esc_phase   = PHASE_PLAIN;
            end
         end
      endcase
      if (l) begin
         if (esc_phase != PHASE_PLAIN) begin
            r.truncated = 1'b1;
            r.out_valid = 1'b0;
            r.out_byte  = 8'h00;
         end
         esc_phase = PHASE_PLAIN;
         esc_high  = 5'd0;
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      upd_result_type want;
      if (reset) begin
         decoded_q.delete();
         esc_phase = PHASE_PLAIN;
         esc_high  = 5'd0;
      end else begin
         if (req_valid && req_ready) begin
            predict_decode(req_in_byte, req_in_last, want);
            decoded_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0h/%b/%b/%b", $time,
                        rsp_out_byte, rsp_out_valid, rsp_truncated, rsp_out_last);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("out_valid", 8'(want.out_valid), 8'(rsp_out_valid));
               check_field("truncated", 8'(want.truncated), 8'(rsp_truncated));
               check_field("out_last", 8'(want.out_last), 8'(rsp_out_last));
            end
         end
      end
      fail_count    <= mismatches;
      words_pending <= decoded_q.size();
   end

endmodule

@@ tb/sv/url_percent_decoder_unit_tb.sv @@
module url_percent_decoder_unit_tb
   import upd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1350;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 150;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_valid;
   logic       rsp_truncated;
   logic       rsp_out_last;

   int fail_count;
   int words_pending;
   int cycle_count = 0;
   int words_sent  = 0;
   bit send_steady = 1'b0;

   url_percent_decoder_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_truncated (rsp_truncated),
      .rsp_out_last  (rsp_out_last)
   );

   // watches both channels, predicts every decoded word and compares
   upd_stream_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_truncated (rsp_truncated),
      .rsp_out_last  (rsp_out_last),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop if the handshakes ever hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // offer one raw byte, after a random gap unless in a steady stretch
   task automatic send_word(input logic [7:0] b, input logic l);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         // drop valid for the gap, raise it again on a later edge
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      @(posedge clock);
      // hold the word until the block takes it
      while (!req_ready) @(posedge clock);
      words_sent++;
      // switch between gappy and back-to-back stretches
      if (words_sent % 89 == 0) send_steady = ($urandom_range(0, 3) == 0);
   endtask

   // one escape digit: mostly real hex, sometimes g/G, sometimes any byte
   function automatic logic [7:0] pick_digit();
      int k;
      k = $urandom_range(0, 29);
      if (k < 10) return 8'(8'h30 + k);
      if (k < 16) return 8'(8'h61 + k - 10);
      if (k < 22) return 8'(8'h41 + k - 16);
      if (k < 24) return 8'h67;
      if (k < 26) return 8'h47;
      return 8'($urandom_range(0, 255));
   endfunction

   // build one encoded string of plain bytes, pluses and escapes, then send it
   task automatic send_string();
      logic [7:0] text[$];
      int         tokens;
      int         r;
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            // plain byte, anything but the escape marker
            text.push_back(8'($urandom_range(0, 255)));
            if (text[$] == CH_PERCENT) text[$] = 8'h61;
         end else if (r < 45) begin
            text.push_back(CH_PLUS);
         end else if (r < 88) begin
            text.push_back(CH_PERCENT);
            text.push_back(pick_digit());
            text.push_back(pick_digit());
         end else begin
            // noise, may even start a stray escape
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      // now and then cut the string off inside an escape
      r = $urandom_range(0, 9);
      if (r == 0) begin
         text.push_back(CH_PERCENT);
      end else if (r == 1) begin
         text.push_back(CH_PERCENT);
         text.push_back(pick_digit());
      end
      foreach (text[i]) send_word(text[i], i == text.size() - 1);
   endtask

   // stimulus: directed corners first, then random strings
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // raw zero and all-ones pass through, plus becomes a space
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(CH_PLUS, 1'b0);
      // ordinary escape
      send_word(CH_PERCENT, 1'b0);
      send_word("4", 1'b0);
      send_word("1", 1'b0);
      // escape of zero is dropped
      send_word(CH_PERCENT, 1'b0);
      send_word("0", 1'b0);
      send_word("0", 1'b0);
      // g as high digit wraps to zero and is dropped
      send_word(CH_PERCENT, 1'b0);
      send_word("g", 1'b0);
      send_word("0", 1'b0);
      // G high digit with a low digit keeps the low 8 bits
      send_word(CH_PERCENT, 1'b0);
      send_word("G", 1'b0);
      send_word("f", 1'b0);
      // mixed case top value
      send_word(CH_PERCENT, 1'b0);
      send_word("F", 1'b0);
      send_word("f", 1'b0);
      // non-hex digits are taken as zero, even another percent or plus
      send_word(CH_PERCENT, 1'b0);
      send_word(CH_PERCENT, 1'b0);
      send_word(CH_PLUS, 1'b0);
      // string ends right on the escape marker
      send_word(CH_PERCENT, 1'b1);
      // string ends after the first digit
      send_word(CH_PERCENT, 1'b0);
      send_word("a", 1'b1);
      // single byte string ending in plain text
      send_word("9", 1'b1);

      while (words_sent < RANDOM_WORDS + 25) send_string();

      // last word was taken on this edge, withdraw valid right away
      req_valid <= 1'b0;
      // drain everything still expected, then idle before the verdict
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // receiver: random stalls per word, steady stretches, and two long holds
   initial begin
      int stall;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 97 == 0) steady = ($urandom_range(0, 3) == 0);
         stall = steady ? 0 : $urandom_range(0, 8);
         // long hold so the block fills up and pushes back on req
         if (taken == 250 || taken == 800) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

endmodule

@@ sim.f @@
sv/upd_pkg.sv
sv/upd_step.sv
sv/url_percent_decoder_unit.sv
tb/sv/upd_stream_checker.sv
tb/sv/url_percent_decoder_unit_tb.sv
